// ===== src/lpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants for the line pixel rasterizer
// Command codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package lpr_pkg;

	localparam int COORD_BITS_DEF = 11;
	localparam int COLOR_BITS     = 8;
	localparam int RGB_BITS       = 3 * COLOR_BITS;
	localparam int ADDR_BITS      = 32;
	localparam int STRIDE_BITS    = 14;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_IDX_BITS   = 1;
	// pixels are 4 bytes wide
	localparam int PIXEL_SHIFT    = 2;

	localparam logic [ADDR_BITS-1:0]   FRAME_BASE_RST  = '0;
	localparam logic [STRIDE_BITS-1:0] LINE_STRIDE_RST = 14'd2560;

	typedef enum logic {
		ACT_LOAD    = 1'b0,
		ACT_ADVANCE = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_BASE  = 1'b0,
		REG_LINE_STRIDE = 1'b1
	} cfg_reg_t;

	// control flags of the pixel stage
	typedef struct packed {
		logic vld;        // a result word sits in the stage
		logic pix_valid;  // the word carries a real pixel
		logic last;       // final pixel of the line
	} pix_ctrl_t;

endpackage

// ===== src/lpr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_if: channel interfaces of the line pixel rasterizer
// Command, pixel and register write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface lpr_cmd_if #(
	parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              action;
	logic [COORD_BITS-1:0]             x_start;
	logic [COORD_BITS-1:0]             y_start;
	logic [COORD_BITS-1:0]             x_end;
	logic [COORD_BITS-1:0]             y_end;
	logic [lpr_pkg::COLOR_BITS-1:0]    red_in;
	logic [lpr_pkg::COLOR_BITS-1:0]    green_in;
	logic [lpr_pkg::COLOR_BITS-1:0]    blue_in;

	modport source (
		output valid, action, x_start, y_start, x_end, y_end, red_in, green_in, blue_in,
		input  ready
	);
	modport sink (
		input  valid, action, x_start, y_start, x_end, y_end, red_in, green_in, blue_in,
		output ready
	);
endinterface

interface lpr_pix_if #(
	parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              pixel_valid;
	logic [COORD_BITS-1:0]             pixel_x;
	logic [COORD_BITS-1:0]             pixel_y;
	logic [lpr_pkg::ADDR_BITS-1:0]     byte_address;
	logic [lpr_pkg::COLOR_BITS-1:0]    red_out;
	logic [lpr_pkg::COLOR_BITS-1:0]    green_out;
	logic [lpr_pkg::COLOR_BITS-1:0]    blue_out;
	logic                              last_pixel;

	modport source (
		output valid, pixel_valid, pixel_x, pixel_y, byte_address,
		       red_out, green_out, blue_out, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_valid, pixel_x, pixel_y, byte_address,
		       red_out, green_out, blue_out, last_pixel,
		output ready
	);
endinterface

interface lpr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [lpr_pkg::CFG_IDX_BITS-1:0]   reg_index;
	logic [lpr_pkg::CFG_DATA_BITS-1:0]  wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== src/lpr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_core: Bresenham stepper
// Holds the line state, takes commands and registers one pixel per advance.
// ----------------------------------------------------------------------------
module lpr_core #(
	parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	lpr_cmd_if.sink                       cmd,
	output lpr_pkg::pix_ctrl_t            ctrl_s1,
	output logic [COORD_BITS-1:0]         x_s1,
	output logic [COORD_BITS-1:0]         y_s1,
	output logic [lpr_pkg::RGB_BITS-1:0]  color_s1
);
	import lpr_pkg::*;

	localparam int EW = COORD_BITS + 2;

	logic                  active_q;
	logic                  steep_q;
	logic [COORD_BITS-1:0] cur_x_q;
	logic [COORD_BITS-1:0] cur_y_q;
	logic [COORD_BITS-1:0] major_end_q;
	logic [COORD_BITS-1:0] d_major_q;
	logic [COORD_BITS-1:0] d_minor_q;
	logic                  step_down_q;
	logic [EW-1:0]         err_q;
	logic [RGB_BITS-1:0]   color_q;

	// load path
	logic [COORD_BITS-1:0] adx, ady;
	logic                  ld_steep, ld_swap;
	logic [COORD_BITS-1:0] sx0, sy0, sx1, sy1;
	logic [COORD_BITS-1:0] ld_end, ld_dmaj, ld_dmin;
	logic                  ld_down;
	logic [EW-1:0]         ld_err;

	// advance path
	logic                  accept, is_load, is_adv;
	logic                  last;
	logic                  err_pos;
	logic [COORD_BITS-1:0] minor_cur, minor_nxt;

	assign accept  = cmd.valid && cmd.ready;
	assign is_load = accept && (cmd.action == ACT_LOAD);
	assign is_adv  = accept && (cmd.action == ACT_ADVANCE);
	assign cmd.ready = en;

	always_comb begin
		adx = (cmd.x_start >= cmd.x_end) ? cmd.x_start - cmd.x_end : cmd.x_end - cmd.x_start;
		ady = (cmd.y_start >= cmd.y_end) ? cmd.y_start - cmd.y_end : cmd.y_end - cmd.y_start;
		ld_steep = !(ady < adx);
		ld_swap  = ld_steep ? (cmd.y_start > cmd.y_end) : (cmd.x_start > cmd.x_end);
		sx0 = ld_swap ? cmd.x_end   : cmd.x_start;
		sy0 = ld_swap ? cmd.y_end   : cmd.y_start;
		sx1 = ld_swap ? cmd.x_start : cmd.x_end;
		sy1 = ld_swap ? cmd.y_start : cmd.y_end;
		if (ld_steep) begin
			ld_end  = sy1;
			ld_dmaj = sy1 - sy0;
			ld_dmin = adx;
			ld_down = sx1 < sx0;
		end else begin
			ld_end  = sx1;
			ld_dmaj = sx1 - sx0;
			ld_dmin = ady;
			ld_down = sy1 < sy0;
		end
		ld_err = EW'({ld_dmin, 1'b0}) - EW'(ld_dmaj);
	end

	always_comb begin
		last      = (steep_q ? cur_y_q : cur_x_q) == major_end_q;
		err_pos   = !err_q[EW-1] && (err_q != '0);
		minor_cur = steep_q ? cur_x_q : cur_y_q;
		minor_nxt = step_down_q ? minor_cur - 1'b1 : minor_cur + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			steep_q     <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			major_end_q <= '0;
			d_major_q   <= '0;
			d_minor_q   <= '0;
			step_down_q <= 1'b0;
			err_q       <= '0;
			color_q     <= '0;
		end else if (is_load) begin
			active_q    <= 1'b1;
			steep_q     <= ld_steep;
			cur_x_q     <= sx0;
			cur_y_q     <= sy0;
			major_end_q <= ld_end;
			d_major_q   <= ld_dmaj;
			d_minor_q   <= ld_dmin;
			step_down_q <= ld_down;
			err_q       <= ld_err;
			color_q     <= {cmd.red_in, cmd.green_in, cmd.blue_in};
		end else if (is_adv && active_q) begin
			if (last) begin
				active_q <= 1'b0;
			end else begin
				if (err_pos) begin
					if (steep_q) cur_x_q <= minor_nxt;
					else         cur_y_q <= minor_nxt;
					err_q <= err_q + EW'({d_minor_q, 1'b0}) - EW'({d_major_q, 1'b0});
				end else begin
					err_q <= err_q + EW'({d_minor_q, 1'b0});
				end
				if (steep_q) cur_y_q <= cur_y_q + 1'b1;
				else         cur_x_q <= cur_x_q + 1'b1;
			end
		end
	end

	// pixel stage; an idle advance gives an all-zero word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1.vld       <= is_adv;
			ctrl_s1.pix_valid <= is_adv && active_q;
			ctrl_s1.last      <= is_adv && active_q && last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= active_q ? cur_x_q : '0;
			y_s1     <= active_q ? cur_y_q : '0;
			color_s1 <= active_q ? color_q : '0;
		end
	end

endmodule

// ===== src/lpr_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_addr: address stage and output register
// Forms frame_base + y*stride + x*4 and holds the word for the sink.
// ----------------------------------------------------------------------------
module lpr_addr #(
	parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  lpr_pkg::pix_ctrl_t               ctrl_s1,
	input  logic [COORD_BITS-1:0]            x_s1,
	input  logic [COORD_BITS-1:0]            y_s1,
	input  logic [lpr_pkg::RGB_BITS-1:0]     color_s1,
	input  logic [lpr_pkg::ADDR_BITS-1:0]    frame_base,
	input  logic [lpr_pkg::STRIDE_BITS-1:0]  line_stride,
	output logic                             out_vld,
	lpr_pix_if.source                        pix
);
	import lpr_pkg::*;

	localparam int PROD_BITS = COORD_BITS + STRIDE_BITS;

	logic [PROD_BITS-1:0] row_off;
	logic [ADDR_BITS-1:0] addr;

	logic                  vld_q, pvld_q, last_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [RGB_BITS-1:0]   color_q;

	always_comb begin
		row_off = PROD_BITS'(y_s1) * PROD_BITS'(line_stride);
		addr = frame_base + ADDR_BITS'(row_off) + (ADDR_BITS'(x_s1) << PIXEL_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= ctrl_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pvld_q  <= ctrl_s1.pix_valid;
			last_q  <= ctrl_s1.last;
			x_q     <= x_s1;
			y_q     <= y_s1;
			color_q <= color_s1;
			addr_q  <= ctrl_s1.pix_valid ? addr : '0;
		end
	end

	assign out_vld          = vld_q;
	assign pix.valid        = vld_q;
	assign pix.pixel_valid  = pvld_q;
	assign pix.pixel_x      = x_q;
	assign pix.pixel_y      = y_q;
	assign pix.byte_address = addr_q;
	assign pix.red_out      = color_q[2*COLOR_BITS +: COLOR_BITS];
	assign pix.green_out    = color_q[COLOR_BITS +: COLOR_BITS];
	assign pix.blue_out     = color_q[0 +: COLOR_BITS];
	assign pix.last_pixel   = last_q;

endmodule

// ===== src/line_pixel_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_rasterizer: Bresenham line engine with framebuffer addressing
// An advance word passes the pixel stage, then the address multiply into the
// output register; a stall at the output holds both stages.
// Throughput: one command word per cycle while not stalled; loads give no output word.
// Reset: no line active, frame_base 0, line_stride 2560, output empty.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer #(
	parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lpr_cmd_if.sink    cmd,
	lpr_pix_if.source  pix,
	lpr_cfg_if.sink    cfg
);
	import lpr_pkg::*;

	logic                   en;
	logic                   out_vld;
	pix_ctrl_t              ctrl_s1;
	logic [COORD_BITS-1:0]  x_s1, y_s1;
	logic [RGB_BITS-1:0]    color_s1;
	logic [ADDR_BITS-1:0]   frame_base_q;
	logic [STRIDE_BITS-1:0] line_stride_q;

	// whole pipe moves when the output register is free or being drained
	assign en = !out_vld || pix.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q  <= FRAME_BASE_RST;
			line_stride_q <= LINE_STRIDE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.reg_index))
				REG_FRAME_BASE:  frame_base_q  <= cfg.wr_data;
				REG_LINE_STRIDE: line_stride_q <= cfg.wr_data[STRIDE_BITS-1:0];
				default: ;
			endcase
		end
	end

	lpr_core #(.COORD_BITS(COORD_BITS)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cmd      (cmd),
		.ctrl_s1  (ctrl_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.color_s1 (color_s1)
	);

	lpr_addr #(.COORD_BITS(COORD_BITS)) u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctrl_s1     (ctrl_s1),
		.x_s1        (x_s1),
		.y_s1        (y_s1),
		.color_s1    (color_s1),
		.frame_base  (frame_base_q),
		.line_stride (line_stride_q),
		.out_vld     (out_vld),
		.pix         (pix)
	);

	// an accepted advance always lands in the pixel stage
	a_adv_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && cmd.action == ACT_ADVANCE |=> ctrl_s1.vld)
		else $error("advance word lost before pixel stage");

	// a stalled pixel stage keeps its word
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s1.vld && !en |=> ctrl_s1.vld && $stable(x_s1) && $stable(y_s1))
		else $error("pixel stage dropped a word under stall");

	// idle words are all zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && !pix.pixel_valid |-> pix.byte_address == '0 && !pix.last_pixel
			&& pix.pixel_x == '0 && pix.pixel_y == '0)
		else $error("idle word carries nonzero fields");

	// a pixel flagged as last must be a real pixel
	a_last_real: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s1.last |-> ctrl_s1.pix_valid && ctrl_s1.vld)
		else $error("last flag on a non-pixel word");

endmodule
